// ----- src/gbr_pkg.sv -----
// gbr_pkg: shared types and constants for the gf2 basis rank block
// beat payload structs, controller state enum, command and status structs
// no dependencies
`default_nettype none

package gbr_pkg;

  // fixed field widths of the beats
  localparam int COL_W         = 64;
  localparam int PIVOT_W       = 6;
  localparam int RANK_W        = 7;
  localparam int VEC_WIDTH_DEF = 64;

  // input beat: one column of the set
  typedef struct packed {
    logic [COL_W-1:0] column_value;
    logic             last_column;
  } col_beat_t;

  // output beat: result for one column
  typedef struct packed {
    logic               independent;
    logic [PIVOT_W-1:0] pivot_bit;
    logic [RANK_W-1:0]  rank_so_far;
    logic               set_done;
  } res_beat_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage : gbr_pkg

`default_nettype wire

// ----- src/gbr_ram.sv -----
// gbr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module gbr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : gbr_ram

`default_nettype wire

// ----- src/gbr_ctrl.sv -----
// gbr_ctrl: controller state machine, sequences accept, bit scan and result load
// depends on gbr_pkg
`default_nettype none

module gbr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          col_valid,
  output logic               col_ready,
  output gbr_pkg::cmd_t      cmd,
  input  wire gbr_pkg::sts_t sts
);

  import gbr_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (col_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    col_ready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.scan   = 1'b0;
    cmd.emit   = 1'b0;
    case (state)
      ST_IDLE: begin
        col_ready  = 1'b1;
        cmd.accept = col_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        col_ready = 1'b0;
      end
    endcase
  end

endmodule : gbr_ctrl

`default_nettype wire

// ----- src/gbr_dp.sv -----
// gbr_dp: datapath with working vector, basis row memory, present bits, rank
// and the result register; depends on gbr_pkg and gbr_ram
`default_nettype none

module gbr_dp #(
  parameter int VEC_WIDTH = gbr_pkg::VEC_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gbr_pkg::col_beat_t col_data,
  input  wire gbr_pkg::cmd_t     cmd,
  output gbr_pkg::sts_t          sts,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output gbr_pkg::res_beat_t     res_data
);

  import gbr_pkg::*;

  localparam int PW = $clog2(VEC_WIDTH);
  localparam int RW = $clog2(VEC_WIDTH + 1);

  // working column and scan bookkeeping
  logic [VEC_WIDTH-1:0] vec;
  logic                 last_flag;
  logic [PW-1:0]        rd_idx;
  logic                 rd_more;
  logic [PW-1:0]        chk_idx;
  logic                 chk_valid;
  logic                 res_indep;
  logic [PW-1:0]        res_pivot;

  // basis bookkeeping
  logic [VEC_WIDTH-1:0] row_present;
  logic [RW-1:0]        rank_count;

  // memory port
  logic [VEC_WIDTH-1:0] row_data;
  logic                 store_now;
  logic                 reduce_now;
  logic                 bit_set;

  gbr_ram #(
    .WIDTH (VEC_WIDTH),
    .DEPTH (VEC_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (store_now),
    .waddr (chk_idx),
    .wdata (vec),
    .raddr (rd_idx),
    .rdata (row_data)
  );

  // decision for the bit position whose row read has returned
  always_comb begin
    bit_set       = vec[chk_idx];
    store_now     = cmd.scan && chk_valid && bit_set && !row_present[chk_idx];
    reduce_now    = cmd.scan && chk_valid && bit_set && row_present[chk_idx];
    sts.scan_last = cmd.scan && chk_valid && (store_now || chk_idx == '0);
    sts.out_free  = !res_valid || res_ready;
  end

  // working vector, read address walk and per-column result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vec       <= col_data.column_value[VEC_WIDTH-1:0];
      last_flag <= col_data.last_column;
      rd_idx    <= PW'(VEC_WIDTH - 1);
      res_indep <= 1'b0;
      res_pivot <= '0;
    end else if (cmd.scan) begin
      if (reduce_now) begin
        vec <= vec ^ row_data;
      end
      if (store_now) begin
        res_indep <= 1'b1;
        res_pivot <= chk_idx;
      end
      chk_idx <= rd_idx;
      if (rd_idx != '0) begin
        rd_idx <= rd_idx - 1'b1;
      end
    end
  end

  // scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_more   <= 1'b0;
      chk_valid <= 1'b0;
    end else if (cmd.accept) begin
      rd_more   <= 1'b1;
      chk_valid <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid <= rd_more && !sts.scan_last;
      if (rd_idx == '0) begin
        rd_more <= 1'b0;
      end
    end
  end

  // present bits and rank, cleared after the last column of a set
  always_ff @(posedge clk) begin
    if (rst) begin
      row_present <= '0;
      rank_count  <= '0;
    end else if (cmd.emit && last_flag) begin
      row_present <= '0;
      rank_count  <= '0;
    end else if (store_now) begin
      row_present[chk_idx] <= 1'b1;
      rank_count           <= rank_count + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_data.independent <= res_indep;
      res_data.pivot_bit   <= PIVOT_W'(res_pivot);
      res_data.rank_so_far <= RANK_W'(rank_count);
      res_data.set_done    <= last_flag;
    end
  end

  // rank always matches the number of present rows
  a_rank_count : assert property (@(posedge clk) disable iff (rst)
    $countones(row_present) == int'(rank_count))
    else $error("rank count out of step with present rows");

  // rank stays within the vector width
  a_rank_max : assert property (@(posedge clk) disable iff (rst)
    int'(rank_count) <= VEC_WIDTH)
    else $error("rank exceeds vector width");

  // a loaded result is offered on the next cycle
  a_emit_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> res_valid)
    else $error("result not presented after load");

  // end of set empties the basis
  a_set_clear : assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && last_flag) |=> (rank_count == '0 && row_present == '0))
    else $error("basis not cleared after last column");

  // a store happens only on the scan step that ends the column
  a_store_ends : assert property (@(posedge clk) disable iff (rst)
    store_now |-> sts.scan_last)
    else $error("store without ending the scan");

endmodule : gbr_dp

`default_nettype wire

// ----- src/gf2_basis_rank_top.sv -----
// Running rank of binary column vectors over GF(2). Each accepted column is reduced
// against an XOR basis held in a VEC_WIDTH x VEC_WIDTH row memory, one row per pivot
// bit. The datapath walks the bit positions from the top down, one position per
// cycle: a set bit with a stored row XORs that row in, a set bit with no row stores
// the column there and ends the walk. The walk is paced by the single read port of
// the row memory, and the next column is taken in the cycle after the result is
// loaded. One column is in work at a time; a new column is taken while the previous
// result still waits in the output register, and a finished column waits until that
// register is free. After a column marked last, the basis is emptied at once; no
// clearing pass is needed after reset.
// depends on gbr_pkg, gbr_ctrl, gbr_dp
`default_nettype none

module gf2_basis_rank_top #(
  parameter int VEC_WIDTH = gbr_pkg::VEC_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               col_valid,
  output logic                    col_ready,
  input  wire gbr_pkg::col_beat_t col_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output gbr_pkg::res_beat_t      res_data
);

  import gbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  gbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  gbr_dp #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .col_data  (col_data),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule : gf2_basis_rank_top

`default_nettype wire

// ----- bench/gbr_rank_checker.sv -----
// gbr_rank_checker: watches the column and result channels of gf2_basis_rank_top
// keeps its own xor basis, predicts each result beat and compares field by field
// depends on gbr_pkg
module gbr_rank_checker #(
  parameter int VEC_WIDTH = gbr_pkg::VEC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               col_valid,
  input  logic               col_ready,
  input  gbr_pkg::col_beat_t col_data,
  input  logic               res_valid,
  input  logic               res_ready,
  input  gbr_pkg::res_beat_t res_data,
  output int                 mismatch_count,
  output int                 results_owed
);

  import gbr_pkg::*;

  // columns only carry VEC_WIDTH rows
  localparam logic [COL_W-1:0] ROW_MASK = {COL_W{1'b1}} >> (COL_W - VEC_WIDTH);
  localparam logic [RANK_W-1:0] FULL_RANK = RANK_W'(COL_W);

  // predicted basis: one row per pivot bit
  logic [COL_W-1:0]  basis_row [COL_W];
  logic [COL_W-1:0]  row_held;
  logic [RANK_W-1:0] basis_rank;
  res_beat_t         pending_ranks[$];

  // reduce one column against the basis and form its result beat
  task automatic reduce_column(input col_beat_t beat, output res_beat_t res);
    logic [COL_W-1:0] v;
    int               msb;
    bit               stored;
    v      = beat.column_value & ROW_MASK;
    res    = '0;
    stored = 1'b0;
    while (v != '0 && !stored) begin
      msb = COL_W - 1;
      while (!v[msb]) msb--;
      if (row_held[msb]) begin
        v ^= basis_row[msb];
      end else begin
        basis_row[msb] = v;
        row_held[msb]  = 1'b1;
        if (basis_rank < FULL_RANK) basis_rank++;
        res.independent = 1'b1;
        res.pivot_bit   = PIVOT_W'(msb);
        stored          = 1'b1;
      end
    end
    res.rank_so_far = basis_rank;
    res.set_done    = beat.last_column;
    // end of set empties the basis after the result is formed
    if (beat.last_column) begin
      row_held   = '0;
      basis_rank = '0;
    end
  endtask

  // compare one field, return 1 on a mismatch
  function automatic int field_differs(string field, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    return 1;
  endfunction

  // sample both channels at the clock edge
  always @(posedge clk) begin : watch
    res_beat_t want;
    res_beat_t predicted;
    int        bad;
    int        pushed;
    int        popped;
    bad    = 0;
    pushed = 0;
    popped = 0;
    if (rst) begin
      row_held   = '0;
      basis_rank = '0;
      pending_ranks.delete();
      mismatch_count <= 0;
      results_owed   <= 0;
    end else begin
      // column beat accepted: predict its result
      if (col_valid && col_ready) begin
        reduce_column(col_data, predicted);
        pending_ranks.push_back(predicted);
        pushed = 1;
      end
      // result beat accepted: check against the oldest prediction
      if (res_valid && res_ready) begin
        if (pending_ranks.size() == 0) begin
          $display("%0t: unexpected result beat, actual %p", $time, res_data);
          bad = 1;
        end else begin
          want   = pending_ranks.pop_front();
          popped = 1;
          bad += field_differs("independent", int'(want.independent),
                               int'(res_data.independent));
          bad += field_differs("pivot_bit", int'(want.pivot_bit),
                               int'(res_data.pivot_bit));
          bad += field_differs("rank_so_far", int'(want.rank_so_far),
                               int'(res_data.rank_so_far));
          bad += field_differs("set_done", int'(want.set_done),
                               int'(res_data.set_done));
        end
      end
      mismatch_count <= mismatch_count + bad;
      results_owed   <= results_owed + pushed - popped;
    end
  end

endmodule

// ----- bench/tb_gf2_basis_rank_top.sv -----
// tb_gf2_basis_rank_top: column stimulus, result back-pressure and the verdict
// for gf2_basis_rank_top; checking is done by gbr_rank_checker
// depends on gbr_pkg, gbr_rank_checker and the block under test
module tb_gf2_basis_rank_top;

  import gbr_pkg::*;

  localparam int VEC_W       = VEC_WIDTH_DEF;
  localparam int RANDOM_BEATS = 600;
  localparam int CALM_AFTER   = 540;
  localparam int SETTLE_CYCLES = VEC_W + 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      col_valid = 1'b0;
  logic      col_ready;
  col_beat_t col_data = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_beat_t res_data;
  int        mismatch_count;
  int        results_owed;
  bit        calm = 1'b0;

  always #1 clk = ~clk;

  gf2_basis_rank_top #(
    .VEC_WIDTH(VEC_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .col_valid(col_valid),
    .col_ready(col_ready),
    .col_data (col_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  gbr_rank_checker #(
    .VEC_WIDTH(VEC_W)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .col_valid     (col_valid),
    .col_ready     (col_ready),
    .col_data      (col_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_data      (res_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // columns already sent in the current set, used to build dependent ones
  logic [COL_W-1:0] set_cols[$];

  function automatic logic [COL_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // one column beat, with an optional gap in front of it
  task automatic send_column(input logic [COL_W-1:0] value, input logic last, input bit gaps);
    if (gaps && !calm && $urandom_range(0, 5) == 0) begin
      col_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    col_valid <= 1'b1;
    col_data  <= '{column_value: value, last_column: last};
    @(posedge clk);
    while (!col_ready) @(posedge clk);
    set_cols.push_back(value);
    if (last) set_cols.delete();
  endtask

  // hold off the column side until every result has come back
  task automatic drain_results();
    col_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // random content for one column of an ordinary set
  function automatic logic [COL_W-1:0] pick_column();
    logic [COL_W-1:0] v;
    int               kind;
    kind = $urandom_range(0, 9);
    v    = '0;
    case (kind)
      0, 1, 2: v = rand_word();
      3: begin
        repeat ($urandom_range(1, 3)) v[$urandom_range(0, COL_W - 1)] = 1'b1;
      end
      4: v = (rand_word() & 64'hFF) << $urandom_range(0, COL_W - 8);
      5, 6, 7: begin
        // xor of earlier columns, sometimes nudged off the span
        foreach (set_cols[i]) if ($urandom_range(0, 1)) v ^= set_cols[i];
        if (kind == 7) v[$urandom_range(0, COL_W - 1)] ^= 1'b1;
      end
      8: v = '0;
      default: v = (64'h1 << $urandom_range(0, COL_W - 1)) | (rand_word() >> $urandom_range(1, 63));
    endcase
    return v;
  endfunction

  // result side: random stall bursts, calm stretches, none at the end
  initial begin : result_stalls
    int quiet_left;
    quiet_left = 0;
    forever begin
      @(posedge clk);
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(0, 63) == 0) quiet_left = $urandom_range(20, 200);
      if (!calm && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int               random_beats;
    int               set_len;
    int               mode;
    int               swap_idx;
    int               tmp;
    int               order[COL_W];
    bit               gaps;
    logic [COL_W-1:0] ones;
    ones = '1;
    random_beats = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero column, full and single-bit extremes, reduction to zero
    send_column('0, 1'b0, 1'b1);
    send_column(ones, 1'b0, 1'b1);
    send_column(64'h1, 1'b0, 1'b1);
    send_column(ones, 1'b0, 1'b1);
    send_column(ones ^ 64'h1, 1'b0, 1'b1);
    send_column(64'h8000_0000_0000_0000, 1'b0, 1'b1);
    send_column(64'h5555_5555_5555_5555, 1'b1, 1'b1);
    // a set of one zero column, then a repeated top bit
    send_column('0, 1'b1, 1'b1);
    send_column(64'h8000_0000_0000_0000, 1'b0, 1'b1);
    send_column(64'h8000_0000_0000_0000, 1'b1, 1'b1);
    send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    // long reduction walk through a staircase of rows
    for (int k = COL_W - 1; k >= COL_W - 8; k--) send_column(ones >> (COL_W - 1 - k), 1'b0, 1'b1);
    send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    drain_results();

    // random sets until the beat budget is spent
    mode = 0;
    while (random_beats < RANDOM_BEATS) begin
      gaps = $urandom_range(0, 2) != 0;
      if (random_beats >= CALM_AFTER) calm = 1'b1;
      if (mode == 0 || (random_beats < 450 && $urandom_range(0, 9) == 0)) begin
        // long set: COL_W columns of distinct pivots then dependent ones, or COL_W + 2 or more random columns
        set_len = $urandom_range(2, 8);
        if ($urandom_range(0, 1)) begin
          foreach (order[i]) order[i] = i;
          for (int i = COL_W - 1; i > 0; i--) begin
            swap_idx        = $urandom_range(0, i);
            tmp             = order[i];
            order[i]        = order[swap_idx];
            order[swap_idx] = tmp;
          end
          foreach (order[i])
            send_column((rand_word() >> (COL_W - 1 - order[i])) | (64'h1 << order[i]), 1'b0, gaps);
          random_beats += COL_W;
        end else begin
          set_len += COL_W;
        end
        for (int i = 0; i < set_len; i++) begin
          send_column(rand_word(), i == set_len - 1, gaps);
          random_beats++;
        end
        mode = 1;
      end else if ($urandom_range(0, 4) == 0) begin
        // short sets of arbitrary columns
        set_len = $urandom_range(1, 4);
        for (int i = 0; i < set_len; i++) begin
          send_column($urandom_range(0, 1) ? rand_word() : '0, i == set_len - 1, gaps);
          random_beats++;
        end
      end else begin
        set_len = $urandom_range(2, 20);
        for (int i = 0; i < set_len; i++) begin
          send_column(pick_column(), i == set_len - 1, gaps);
          random_beats++;
        end
      end
      if (!calm && $urandom_range(0, 9) == 0) drain_results();
    end

    // wait out the last results and any stray beat
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
